// File: rtl/xfc_pkg.sv
package xfc_pkg;

    // Field widths of the transactions and of the internal code records.
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 80;
    localparam int ACC_W   = CODE_W + BYTE_W;
    localparam int CNT_W   = 7;

    // Constants of the code format.
    localparam logic [CNT_W-1:0] WORD_BITS     = 7'd64;
    localparam logic [CNT_W-1:0] BYTE_BITS     = 7'd8;
    localparam logic [CNT_W-1:0] ZERO_BITS     = 7'd1;
    localparam logic [CNT_W-1:0] WIN_HDR_BITS  = 7'd2;
    localparam logic [CNT_W-1:0] NEW_HDR_BITS  = 7'd13;
    localparam logic [4:0]       LEAD_MAX      = 5'd31;

    // Control prefixes of the three code kinds.
    localparam logic       CTRL_ZERO   = 1'b0;
    localparam logic [1:0] CTRL_WINDOW = 2'b10;
    localparam logic [1:0] CTRL_NEW    = 2'b11;

    // One input transaction.
    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic               end_of_block;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              block_done;
    } out_item_t;

    // One variable-length code, left aligned, with its bit count.
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [CNT_W-1:0]  nbits;
        logic              last;
    } code_t;

endpackage

// File: rtl/xfc_front.sv
module xfc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  xfc_pkg::in_item_t sample,
    output logic             code_valid,
    input  logic             code_ready,
    output xfc_pkg::code_t   code
);

    // Leading zero count of one byte; the byte is known to be nonzero.
    function automatic logic [2:0] byte_lz(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && b[7-i])
            begin
                n = 3'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Trailing zero count of one byte; the byte is known to be nonzero.
    function automatic logic [2:0] byte_tz(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!found && b[i])
            begin
                n = 3'(i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Stream state kept by the front part.
    logic [63:0] prev_reg;
    logic [4:0]  wl_reg, wl_next;
    logic [5:0]  wt_reg, wt_next;
    logic        first_reg, first_next;

    // Stage 1: the XOR with the previous value.
    logic        s1_valid_reg;
    logic [63:0] s1_x_reg;
    logic        s1_last_reg;

    // Stage 2: zero counts of the XOR.
    logic        s2_valid_reg;
    logic [63:0] s2_x_reg;
    logic        s2_last_reg;
    logic        s2_zero_reg;
    logic [4:0]  s2_lead_reg;
    logic [5:0]  s2_trail_reg;

    logic        s1_ready, s2_ready, accept, write;
    logic [7:0]  byte_nz;
    logic [6:0]  lead_full;
    logic [5:0]  trail_calc;
    logic [4:0]  lead_calc;
    logic        lead_found, trail_found;
    logic        win_ok;
    logic [6:0]  win_width, new_len;

    // Pipeline flow: a stage moves when the one after it can take its content.
    assign write      = s2_valid_reg && code_ready;
    assign s2_ready   = !s2_valid_reg || code_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign full       = !s1_ready;
    assign accept     = push && s1_ready;
    assign code_valid = s2_valid_reg;

    // Zero counts of the XOR, byte by byte and then across the bytes.
    always_comb
    begin
        lead_full = 7'd0;
        trail_calc = 6'd0;
        lead_found = 1'b0;
        trail_found = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            byte_nz[j] = |s1_x_reg[8*j +: 8];
        end
        for (int k = 0; k < 8; k++)
        begin
            if (!lead_found && byte_nz[7-k])
            begin
                lead_full = 7'(8*k) + 7'(byte_lz(s1_x_reg[8*(7-k) +: 8]));
                lead_found = 1'b1;
            end
            if (!trail_found && byte_nz[k])
            begin
                trail_calc = 6'(8*k) + 6'(byte_tz(s1_x_reg[8*k +: 8]));
                trail_found = 1'b1;
            end
        end
        lead_calc = (lead_full > 7'(xfc_pkg::LEAD_MAX)) ? xfc_pkg::LEAD_MAX : lead_full[4:0];
    end

    // Classification and code assembly against the stored window.
    always_comb
    begin
        win_ok = !first_reg && (s2_lead_reg >= wl_reg) && (s2_trail_reg >= wt_reg);
        win_width = xfc_pkg::WORD_BITS - 7'(wl_reg) - 7'(wt_reg);
        new_len = xfc_pkg::WORD_BITS - 7'(s2_lead_reg) - 7'(s2_trail_reg);
        wl_next = wl_reg;
        wt_next = wt_reg;
        code.last = s2_last_reg;
        if (s2_zero_reg)
        begin
            code.bits = {xfc_pkg::CTRL_ZERO, 79'd0};
            code.nbits = xfc_pkg::ZERO_BITS;
        end
        else if (win_ok)
        begin
            code.bits = {xfc_pkg::CTRL_WINDOW, s2_x_reg << wl_reg, 14'd0};
            code.nbits = xfc_pkg::WIN_HDR_BITS + win_width;
        end
        else
        begin
            code.bits = {xfc_pkg::CTRL_NEW, s2_lead_reg, new_len[5:0],
                         s2_x_reg << s2_lead_reg, 3'd0};
            code.nbits = xfc_pkg::NEW_HDR_BITS + new_len;
            wl_next = s2_lead_reg;
            wt_next = s2_trail_reg;
        end
        first_next = 1'b0;
        if (s2_last_reg)
        begin
            wl_next = 5'd0;
            wt_next = 6'd0;
            first_next = 1'b1;
        end
    end

    // Control state and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            prev_reg     <= 64'd0;
            wl_reg       <= 5'd0;
            wt_reg       <= 6'd0;
            first_reg    <= 1'b1;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                prev_reg <= sample.end_of_block ? 64'd0 : sample.value_bits;
            end
            if (write)
            begin
                wl_reg    <= wl_next;
                wt_reg    <= wt_next;
                first_reg <= first_next;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= sample.value_bits ^ prev_reg;
            s1_last_reg <= sample.end_of_block;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_x_reg     <= s1_x_reg;
            s2_last_reg  <= s1_last_reg;
            s2_zero_reg  <= !(|byte_nz);
            s2_lead_reg  <= lead_calc;
            s2_trail_reg <= trail_calc;
        end
    end

endmodule

// File: rtl/xfc_fifo.sv
module xfc_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  xfc_pkg::code_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output xfc_pkg::code_t rd_data,
    output logic           empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    xfc_pkg::code_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/xfc_back.sv
module xfc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               code_empty,
    input  xfc_pkg::code_t     code,
    output logic               code_rd,
    output logic               empty,
    input  logic               pop,
    output xfc_pkg::out_item_t result
);

    logic [xfc_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [xfc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      last_pending_reg, last_pending_next;
    logic                      out_valid_reg, out_valid_next;
    xfc_pkg::out_item_t        out_reg;
    logic                      slot_free, emit, load, done;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // A byte leaves when eight bits wait, or when the block ends with fewer.
    assign slot_free = !out_valid_reg || pop;
    assign emit = slot_free && ((cnt_reg >= xfc_pkg::BYTE_BITS) ||
                                (last_pending_reg && (cnt_reg != '0)));
    assign load = !code_empty && (cnt_reg < xfc_pkg::BYTE_BITS) && !last_pending_reg;
    assign done = last_pending_reg && (cnt_reg <= xfc_pkg::BYTE_BITS);
    assign code_rd = load;

    // Bit accumulator: pending bits sit at the top, zeros below them.
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        last_pending_next = last_pending_reg;
        out_valid_next = out_valid_reg && !pop;
        if (load)
        begin
            acc_next = acc_reg | ({code.bits, 8'd0} >> cnt_reg[2:0]);
            cnt_next = cnt_reg + code.nbits;
            last_pending_next = code.last;
        end
        else if (emit)
        begin
            acc_next = acc_reg << xfc_pkg::BYTE_W;
            cnt_next = (cnt_reg >= xfc_pkg::BYTE_BITS) ? cnt_reg - xfc_pkg::BYTE_BITS : '0;
            out_valid_next = 1'b1;
            if (done)
            begin
                last_pending_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            cnt_reg          <= '0;
            last_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            acc_reg          <= acc_next;
            cnt_reg          <= cnt_next;
            last_pending_reg <= last_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.packed_byte <= acc_reg[xfc_pkg::ACC_W-1 -: xfc_pkg::BYTE_W];
            out_reg.block_done  <= done;
        end
    end

endmodule

// File: rtl/xor_float_stream_compressor.sv
// XOR float stream compressor. Each input transaction carries the 64-bit
// pattern of one double; it is XORed with the previous value and coded as a
// single zero bit, a window code (10 and the bits inside the stored window)
// or a new-window code (11, 5-bit leading count, 6-bit length, the bits).
// The code stream leaves as bytes, most significant bit first, one result
// transaction per byte; the transaction marked end_of_block flushes a
// zero-padded partial byte, flags the last byte with block_done and returns
// the block to its reset state. An input is taken every cycle while the code
// queue has room; an accepted input passes the XOR stage, the zero-count stage
// and the code queue into the bit accumulator, and its first complete byte
// then goes through the output register to the result ports. The sustained
// rate is set by the byte-wide output register: a new code is loaded only
// while fewer than eight bits wait, so an item takes a load step and a byte
// step per byte it completes, from a repeated value up to a 77-bit code.
module xor_float_stream_compressor
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  xfc_pkg::in_item_t  sample,
    output logic               empty,
    input  logic               pop,
    output xfc_pkg::out_item_t result
);

    xfc_pkg::code_t wr_code, rd_code;
    logic           wr_valid, q_full, q_empty, q_rd;

    // Front part: XOR, zero counts and classification into codes.
    xfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .code_valid (wr_valid),
        .code_ready (!q_full),
        .code       (wr_code)
    );

    // Queue of codes between the two parts.
    xfc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_valid && !q_full),
        .wr_data (wr_code),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (rd_code),
        .empty   (q_empty)
    );

    // Back part: bit packing into bytes.
    xfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_empty (q_empty),
        .code       (rd_code),
        .code_rd    (q_rd),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
